/* hdl/nsvr_pkg.sv */
// Shared types, character codes and helpers for the sentence volume receiver.
// No dependencies; the parser and the top level in hdl/ refer to this package.
package nsvr_pkg;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TEXT,
        PH_HEX_HI,
        PH_HEX_LO
    } frame_phase_t;

    typedef enum logic [3:0] {
        PP_S,
        PP_B,
        PP_C,
        PP_SKIP1,
        PP_V,
        PP_O,
        PP_L,
        PP_SKIP2,
        PP_DIGITS,
        PP_DONE,
        PP_REJECT
    } parse_phase_t;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_B      = 8'h42;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_V      = 8'h56;
    localparam logic [7:0] CH_O      = 8'h4F;
    localparam logic [7:0] CH_L      = 8'h4C;
    localparam logic [7:0] VOLUME_MAX = 8'd100;

    typedef struct packed {
        logic [7:0] rx_byte;
    } rx_beat_t;

    typedef struct packed {
        logic       checksum_match;
        logic       volume_valid;
        logic [6:0] volume_value;
        logic       overrun;
    } res_beat_t;

    typedef struct packed {
        logic       restart;
        logic       step;
        logic [7:0] ch;
    } parse_ctl_t;

    typedef struct packed {
        logic       is_cmd;
        logic [7:0] value;
    } parse_sts_t;

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'h00;
            if (c >= CH_0 && c <= CH_9)
                d = c - CH_0;
            else if (c >= CH_UA && c <= CH_UF)
                d = c - CH_UA + 8'd10;
            else if (c >= CH_LA && c <= CH_LF)
                d = c - CH_LA + 8'd10;
            return d[3:0];
        end
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

endpackage

/* hdl/nsvr_stream_if.sv */
// Valid/ready stream channel carrying one beat of a given payload type.
// Payload types come from nsvr_pkg.
interface nsvr_stream_if #(
    parameter type payload_t = logic [7:0]
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* hdl/nsvr_cmd_parser.sv */
// On-the-fly matcher for "SBC<any>,VOL<any>,<digits>" with a decimal accumulator.
// Depends on nsvr_pkg for the parse phase type and control/status structs.
module nsvr_cmd_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  nsvr_pkg::parse_ctl_t ctl,
    output nsvr_pkg::parse_sts_t sts
);

    nsvr_pkg::parse_phase_t phase_reg, phase_next;
    logic [7:0]             accum_reg, accum_next;
    logic [7:0]             digit;

    assign digit = ctl.ch - nsvr_pkg::CH_0;

    always_comb
    begin
        phase_next = phase_reg;
        accum_next = accum_reg;
        if (ctl.restart)
        begin
            phase_next = nsvr_pkg::PP_S;
            accum_next = 8'd0;
        end
        else if (ctl.step)
        begin
            unique case (phase_reg)
                nsvr_pkg::PP_S:
                    phase_next = (ctl.ch == nsvr_pkg::CH_S) ? nsvr_pkg::PP_B : nsvr_pkg::PP_REJECT;
                nsvr_pkg::PP_B:
                    phase_next = (ctl.ch == nsvr_pkg::CH_B) ? nsvr_pkg::PP_C : nsvr_pkg::PP_REJECT;
                nsvr_pkg::PP_C:
                    phase_next = (ctl.ch == nsvr_pkg::CH_C) ? nsvr_pkg::PP_SKIP1
                                                            : nsvr_pkg::PP_REJECT;
                nsvr_pkg::PP_SKIP1:
                    if (ctl.ch == nsvr_pkg::CH_COMMA)
                        phase_next = nsvr_pkg::PP_V;
                nsvr_pkg::PP_V:
                    phase_next = (ctl.ch == nsvr_pkg::CH_V) ? nsvr_pkg::PP_O : nsvr_pkg::PP_REJECT;
                nsvr_pkg::PP_O:
                    phase_next = (ctl.ch == nsvr_pkg::CH_O) ? nsvr_pkg::PP_L : nsvr_pkg::PP_REJECT;
                nsvr_pkg::PP_L:
                    phase_next = (ctl.ch == nsvr_pkg::CH_L) ? nsvr_pkg::PP_SKIP2
                                                            : nsvr_pkg::PP_REJECT;
                nsvr_pkg::PP_SKIP2:
                    if (ctl.ch == nsvr_pkg::CH_COMMA)
                        phase_next = nsvr_pkg::PP_DIGITS;
                nsvr_pkg::PP_DIGITS:
                    if (nsvr_pkg::is_digit(ctl.ch))
                        accum_next = (accum_reg << 3) + (accum_reg << 1) + digit;
                    else
                        phase_next = nsvr_pkg::PP_DONE;
                default:
                    phase_next = phase_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= nsvr_pkg::PP_S;
            accum_reg <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            accum_reg <= accum_next;
        end
    end

    assign sts.is_cmd = (phase_reg == nsvr_pkg::PP_DIGITS) || (phase_reg == nsvr_pkg::PP_DONE);
    assign sts.value  = accum_reg;

endmodule

/* hdl/nmea_sentence_volume_receiver.sv */
// Top level: sentence framing, running XOR, checksum compare and result register.
// Depends on nsvr_pkg, nsvr_stream_if and nsvr_cmd_parser.
//
// Takes one received byte per clock cycle, back to back. A '$' opens a sentence,
// text runs up to '*', and two hex checksum characters follow; the second one
// produces a single result beat, which appears in the output register on the next
// cycle. Framing, XOR and command parsing each register their update from the byte
// just taken, so the only limit on rate is the single-entry output register: rx
// ready drops only while a result waits and the result side is stalled. Text longer
// than MAX_SENTENCE_LEN bytes sets overrun and suppresses the volume setting.
module nmea_sentence_volume_receiver #(
    parameter int MAX_SENTENCE_LEN = 128
) (
    input  logic           clk,
    input  logic           rst_n,
    nsvr_stream_if.sink    rx,
    nsvr_stream_if.source  res
);

    localparam logic [7:0] MaxLen = 8'(MAX_SENTENCE_LEN);

    nsvr_pkg::frame_phase_t phase_reg, phase_next;
    logic [7:0]             len_reg;
    logic [7:0]             xor_reg;
    logic [3:0]             chk_hi_reg;
    logic                   ended_reg;
    logic                   overrun_reg;
    logic                   res_valid_reg, res_valid_next;
    nsvr_pkg::res_beat_t    res_reg, res_next;

    nsvr_pkg::rx_beat_t     beat;
    logic                   rx_fire;
    logic                   ended_now;
    logic                   start;
    logic                   text_byte;
    logic                   emit;
    logic [7:0]             chk_full;
    logic                   match;
    logic                   vol_ok;
    nsvr_pkg::parse_ctl_t   pctl;
    nsvr_pkg::parse_sts_t   psts;

    assign beat     = rx.payload;
    assign rx.ready = !res_valid_reg || res.ready;
    assign rx_fire  = rx.valid && rx.ready;

    always_comb
    begin
        phase_next = phase_reg;
        if (rx_fire)
        begin
            unique case (phase_reg)
                nsvr_pkg::PH_IDLE:
                    if (beat.rx_byte == nsvr_pkg::CH_DOLLAR)
                        phase_next = nsvr_pkg::PH_TEXT;
                nsvr_pkg::PH_TEXT:
                    if (beat.rx_byte == nsvr_pkg::CH_STAR)
                        phase_next = nsvr_pkg::PH_HEX_HI;
                nsvr_pkg::PH_HEX_HI:
                    phase_next = nsvr_pkg::PH_HEX_LO;
                nsvr_pkg::PH_HEX_LO:
                    phase_next = nsvr_pkg::PH_IDLE;
                default:
                    phase_next = nsvr_pkg::PH_IDLE;
            endcase
        end
    end

    always_comb
    begin
        start     = rx_fire && (phase_reg == nsvr_pkg::PH_IDLE)
                    && (beat.rx_byte == nsvr_pkg::CH_DOLLAR);
        text_byte = rx_fire && (phase_reg == nsvr_pkg::PH_TEXT)
                    && (beat.rx_byte != nsvr_pkg::CH_STAR);
        emit      = rx_fire && (phase_reg == nsvr_pkg::PH_HEX_LO);
        ended_now = ended_reg || (beat.rx_byte == nsvr_pkg::CH_NUL);
        pctl.restart = start;
        pctl.step    = text_byte && !ended_now;
        pctl.ch      = beat.rx_byte;
    end

    nsvr_cmd_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (pctl),
        .sts   (psts)
    );

    assign chk_full = {chk_hi_reg, nsvr_pkg::hex_nibble(beat.rx_byte)};
    assign match    = (chk_full == xor_reg);
    assign vol_ok   = match && !overrun_reg && psts.is_cmd && (psts.value <= nsvr_pkg::VOLUME_MAX);

    always_comb
    begin
        res_next.checksum_match = match;
        res_next.volume_valid   = vol_ok;
        res_next.volume_value   = vol_ok ? psts.value[6:0] : 7'd0;
        res_next.overrun        = overrun_reg;
        if (emit)
            res_valid_next = 1'b1;
        else if (res.ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= nsvr_pkg::PH_IDLE;
            len_reg       <= 8'd0;
            xor_reg       <= 8'd0;
            chk_hi_reg    <= 4'd0;
            ended_reg     <= 1'b0;
            overrun_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            res_valid_reg <= res_valid_next;
            if (start)
            begin
                len_reg     <= 8'd0;
                xor_reg     <= 8'd0;
                ended_reg   <= 1'b0;
                overrun_reg <= 1'b0;
            end
            else if (text_byte)
            begin
                if (len_reg >= MaxLen)
                    overrun_reg <= 1'b1;
                else
                    len_reg <= len_reg + 8'd1;
                ended_reg <= ended_now;
                if (!ended_now)
                    xor_reg <= xor_reg ^ beat.rx_byte;
            end
            if (rx_fire && (phase_reg == nsvr_pkg::PH_HEX_HI))
                chk_hi_reg <= nsvr_pkg::hex_nibble(beat.rx_byte);
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            res_reg <= res_next;
    end

    assign res.valid   = res_valid_reg;
    assign res.payload = res_reg;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= MaxLen)
        else $error("text length beyond limit");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(phase_reg == nsvr_pkg::PH_HEX_LO))
        else $error("result without second checksum byte");

    a_volume_gated: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.volume_valid |-> res_reg.checksum_match && !res_reg.overrun)
        else $error("volume reported on bad or overlong sentence");

    a_volume_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_reg.volume_valid && res_reg.volume_value <= 7'd100)
                          || (!res_reg.volume_valid && res_reg.volume_value == 7'd0))
        else $error("volume value out of range");

endmodule

/* verif/tb_nmea_sentence_volume_receiver.sv */
// Self-checking testbench for nmea_sentence_volume_receiver: feeds framed sentences,
// noise and broken frames, and predicts every checksum/volume report cycle-free.
// Depends on hdl/nsvr_pkg.sv, hdl/nsvr_stream_if.sv and the receiver RTL.
module tb_nmea_sentence_volume_receiver;
    timeunit 1ns;
    timeprecision 1ps;

    import nsvr_pkg::*;

    localparam int SENTENCE_LIMIT = 128;
    localparam int CYCLE_LIMIT    = 300000;
    localparam int LONG_HOLD      = 400;
    localparam logic [7:0] CH_UZ  = 8'h5A;

    logic clk = 1'b0;
    logic rst_n;

    nsvr_stream_if #(.payload_t(rx_beat_t))  rx_ch ();
    nsvr_stream_if #(.payload_t(res_beat_t)) res_ch ();

    nmea_sentence_volume_receiver #(
        .MAX_SENTENCE_LEN(SENTENCE_LIMIT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .rx(rx_ch.sink),
        .res(res_ch.source)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    logic [7:0]   tx_bytes[$];
    res_beat_t    expected_reports[$];
    logic [7:0]   body[$];
    res_beat_t    want;
    int           pushed;
    int           tx_idle_pct;
    int           rx_idle_pct;
    int           hold_left;
    int           cycle_count;
    bit           long_hold_req;
    bit           long_hold_done;
    bit           failed;

    frame_phase_t sent_phase;
    parse_phase_t cmd_phase;
    logic [7:0]   body_len;
    logic [7:0]   body_xor;
    logic [7:0]   sum_rx;
    logic [7:0]   cmd_value;
    logic         body_cut;
    logic         body_overrun;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9)
            return c[3:0];
        if ((c >= CH_UA && c <= CH_UF) || (c >= CH_LA && c <= CH_LF))
            return c[3:0] + 4'd9;
        return 4'h0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10)
            return CH_0 + 8'(n);
        return (lower ? CH_LA : CH_UA) + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] filler();
        return 8'($urandom_range(CH_UA, CH_UZ));
    endfunction

    task automatic advance_command(input logic [7:0] c);
        case (cmd_phase)
            PP_S:      cmd_phase = (c == CH_S) ? PP_B : PP_REJECT;
            PP_B:      cmd_phase = (c == CH_B) ? PP_C : PP_REJECT;
            PP_C:      cmd_phase = (c == CH_C) ? PP_SKIP1 : PP_REJECT;
            PP_SKIP1:  if (c == CH_COMMA) cmd_phase = PP_V;
            PP_V:      cmd_phase = (c == CH_V) ? PP_O : PP_REJECT;
            PP_O:      cmd_phase = (c == CH_O) ? PP_L : PP_REJECT;
            PP_L:      cmd_phase = (c == CH_L) ? PP_SKIP2 : PP_REJECT;
            PP_SKIP2:  if (c == CH_COMMA) cmd_phase = PP_DIGITS;
            PP_DIGITS:
            begin
                if (c >= CH_0 && c <= CH_9)
                    cmd_value = cmd_value * 8'd10 + (c - CH_0);
                else
                    cmd_phase = PP_DONE;
            end
            default: ;
        endcase
    endtask

    task automatic decode_rx_byte(input logic [7:0] c);
        res_beat_t rep;
        logic      vol_ok;
        case (sent_phase)
            PH_IDLE:
            begin
                if (c == CH_DOLLAR)
                begin
                    body_len     = 8'd0;
                    body_xor     = 8'd0;
                    cmd_phase    = PP_S;
                    cmd_value    = 8'd0;
                    body_cut     = 1'b0;
                    body_overrun = 1'b0;
                    sent_phase   = PH_TEXT;
                end
            end
            PH_TEXT:
            begin
                if (c == CH_STAR)
                    sent_phase = PH_HEX_HI;
                else
                begin
                    if (body_len >= SENTENCE_LIMIT)
                        body_overrun = 1'b1;
                    else
                        body_len = body_len + 8'd1;
                    if (c == CH_NUL)
                        body_cut = 1'b1;
                    if (!body_cut)
                    begin
                        body_xor = body_xor ^ c;
                        advance_command(c);
                    end
                end
            end
            PH_HEX_HI:
            begin
                sum_rx     = {hex_value(c), 4'h0};
                sent_phase = PH_HEX_LO;
            end
            default:
            begin
                sum_rx[3:0] = hex_value(c);
                sent_phase  = PH_IDLE;
                rep.checksum_match = (sum_rx == body_xor);
                vol_ok = rep.checksum_match && !body_overrun &&
                         (cmd_phase == PP_DIGITS || cmd_phase == PP_DONE) &&
                         cmd_value <= VOLUME_MAX;
                rep.volume_valid = vol_ok;
                rep.volume_value = vol_ok ? cmd_value[6:0] : 7'd0;
                rep.overrun      = body_overrun;
                expected_reports.push_back(rep);
            end
        endcase
    endtask

    task automatic check_field(input string field, input int exp_v, input int got_v);
        if (got_v != exp_v)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, exp_v, got_v);
            failed = 1'b1;
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_ch.valid <= 1'b0;
        end
        else
        begin
            if (rx_ch.valid && rx_ch.ready)
                decode_rx_byte(rx_ch.payload.rx_byte);
            if (!rx_ch.valid || rx_ch.ready)
            begin
                if (tx_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    rx_ch.valid   <= 1'b1;
                    rx_ch.payload <= '{rx_byte: tx_bytes.pop_front()};
                end
                else
                begin
                    rx_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $display("%0t ns: report beat with none expected, got %b/%b/%0d/%b",
                             $time, res_ch.payload.checksum_match,
                             res_ch.payload.volume_valid, res_ch.payload.volume_value,
                             res_ch.payload.overrun);
                    failed = 1'b1;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("checksum_match", int'(want.checksum_match),
                                int'(res_ch.payload.checksum_match));
                    check_field("volume_valid", int'(want.volume_valid),
                                int'(res_ch.payload.volume_valid));
                    check_field("volume_value", int'(want.volume_value),
                                int'(res_ch.payload.volume_value));
                    check_field("overrun", int'(want.overrun),
                                int'(res_ch.payload.overrun));
                end
            end
            if (long_hold_req && !long_hold_done)
            begin
                hold_left      = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left    = hold_left - 1;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic put_byte(input logic [7:0] b);
        tx_bytes.push_back(b);
        pushed++;
    endtask

    task automatic append_str(input string s);
        for (int i = 0; i < s.len(); i++)
            body.push_back(s[i]);
    endtask

    task automatic send_framed(input logic [7:0] hi, input logic [7:0] lo);
        put_byte(CH_DOLLAR);
        foreach (body[i])
            put_byte(body[i]);
        put_byte(CH_STAR);
        put_byte(hi);
        put_byte(lo);
    endtask

    task automatic send_sentence(input bit good_sum);
        logic [7:0] x;
        x = 8'd0;
        foreach (body[i])
        begin
            if (body[i] == CH_NUL)
                break;
            x = x ^ body[i];
        end
        if (good_sum)
            send_framed(hex_char(x[7:4], $urandom_range(1) == 1),
                        hex_char(x[3:0], $urandom_range(1) == 1));
        else
            send_framed(8'($urandom_range(255)), 8'($urandom_range(255)));
    endtask

    task automatic build_volume_body();
        int v;
        body.delete();
        append_str("SBC");
        if ($urandom_range(9) == 0)
            body[$urandom_range(2)] = filler();
        repeat ($urandom_range(3)) body.push_back(filler());
        if ($urandom_range(19) != 0)
            body.push_back(CH_COMMA);
        append_str("VOL");
        if ($urandom_range(9) == 0)
            body[body.size() - 1 - $urandom_range(2)] = filler();
        repeat ($urandom_range(3)) body.push_back(filler());
        if ($urandom_range(19) != 0)
            body.push_back(CH_COMMA);
        case ($urandom_range(3))
            0: v = -1;
            1: v = $urandom_range(100);
            2: v = $urandom_range(999, 101);
            default: v = $urandom_range(99999);
        endcase
        if (v >= 0)
            append_str($sformatf("%0d", v));
        if ($urandom_range(2) == 0)
        begin
            body.push_back(CH_COMMA);
            repeat ($urandom_range(4)) body.push_back(filler());
        end
        if ($urandom_range(19) == 0)
            body.insert($urandom_range(body.size()), CH_NUL);
        if ($urandom_range(19) == 0)
            body[$urandom_range(body.size() - 1)] = 8'($urandom_range(255));
    endtask

    task automatic queue_random_sentence();
        int roll;
        int goal;
        logic [7:0] b;
        roll = $urandom_range(99);
        if (roll < 4)
        begin
            build_volume_body();
            case ($urandom_range(4))
                0: goal = SENTENCE_LIMIT - 1;
                1: goal = SENTENCE_LIMIT;
                2: goal = SENTENCE_LIMIT + 1;
                3: goal = SENTENCE_LIMIT + 2;
                default: goal = $urandom_range(200, SENTENCE_LIMIT + 3);
            endcase
            body.push_back(CH_COMMA);
            while (body.size() < goal)
                body.push_back(filler());
        end
        else if (roll < 16)
        begin
            body.delete();
            repeat ($urandom_range(20))
            begin
                b = 8'($urandom_range(255));
                body.push_back((b == CH_STAR) ? CH_DOLLAR : b);
            end
        end
        else
        begin
            build_volume_body();
        end
        send_sentence($urandom_range(99) < 85);
        if ($urandom_range(99) < 30)
            repeat ($urandom_range(2, 1)) put_byte(8'($urandom_range(255)));
    endtask

    task automatic wait_drained();
        while (tx_bytes.size() != 0 || rx_ch.valid || expected_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_random(input int n_bytes, input int tx_pct, input int rx_pct);
        int goal;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        goal = pushed + n_bytes;
        while (pushed < goal)
            queue_random_sentence();
        wait_drained();
    endtask

    initial
    begin
        rx_ch.valid   = 1'b0;
        rx_ch.payload = '0;
        res_ch.ready  = 1'b0;
        rst_n         = 1'b0;
        failed        = 1'b0;
        pushed        = 0;
        hold_left     = 0;
        long_hold_req = 1'b0;
        long_hold_done = 1'b0;
        tx_idle_pct   = 9;
        rx_idle_pct   = 77;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        put_byte(CH_NUL);
        put_byte(8'hFF);
        put_byte(CH_STAR);
        body.delete(); append_str("SBC,VOL,100");   send_sentence(1'b1);
        body.delete(); append_str("SBC,VOL,101");   send_sentence(1'b1);
        body.delete(); append_str("SBCab,VOLx,");   send_sentence(1'b1);
        body.delete(); append_str("SBC,VOL,356,A"); send_sentence(1'b1);
        body.delete(); append_str("SBCVOL,5");      send_sentence(1'b1);
        body.delete(); append_str("$SBC,VOL,7");    send_sentence(1'b1);
        body.delete(); append_str("SBC,VOL,42");
        body.push_back(CH_NUL);
        append_str("XYZ");                          send_sentence(1'b1);
        body.delete(); append_str("SBC,VOL,9");     send_framed(CH_DOLLAR, 8'h5A);
        body.delete(); append_str("SBC,VOL,8");     send_sentence(1'b0);
        body.delete();                              send_sentence(1'b1);
        body.delete(); append_str("SBC,VOL,5,");
        while (body.size() < SENTENCE_LIMIT + 1)
            body.push_back(filler());
        send_sentence(1'b1);
        wait_drained();

        run_random(310, 9, 77);
        run_random(310, 77, 9);
        long_hold_req = 1'b1;
        run_random(310, 0, 0);

        repeat (10) @(posedge clk);
        if (!failed)
            $display("tb_nmea_sentence_volume_receiver OK");
        else
            $display("tb_nmea_sentence_volume_receiver NOT OK");
        $finish;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_nmea_sentence_volume_receiver NOT OK");
        $finish;
    end

endmodule
